// ===== hdl/json_string_unescape_utf8_unit_defines.svh =====
// Assertion macros shared by the unescape unit RTL files.
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define JSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu assertion failed");
// Next-cycle implication, checked out of reset.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu assertion failed");
`else
`define JSU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/jsu_pkg.sv =====
// Shared types and constants of the JSON string unescape unit.
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

    // Depth of the request queue between parser and serializer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        ST_DATA       = 4'd0,
        ST_CLOSED     = 4'd1,
        ST_NO_QUOTE   = 4'd2,
        ST_BAD_ESC    = 4'd3,
        ST_BAD_HEX    = 4'd4,
        ST_TRUNCATED  = 4'd5,
        ST_BAD_PAIR   = 4'd6,
        ST_LONE_HALF  = 4'd7,
        ST_UNTERM     = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_TEXT    = 3'd1,
        PH_ESC     = 3'd2,
        PH_HEX1    = 3'd3,
        PH_PAIR_BS = 3'd4,
        PH_PAIR_U  = 3'd5,
        PH_HEX2    = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] status;
        logic       last;
    } out_t;

    // One request: 1 to 4 result items produced by one input byte.
    typedef struct packed {
        logic [1:0]      last_idx;
        status_t         status;
        logic [3:0][7:0] bytes;
    } req_t;

endpackage
`default_nettype wire

// ===== hdl/json_string_unescape_utf8_unit.sv =====
// Top level of the JSON string unescape unit (parser, request queue, serializer).
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one raw document byte per
//   request, starting at the opening quote, or an end-of-input marker.
//   Output channel (out_valid/out_ready/out_data) gives decoded UTF-8 bytes
//   with status 0, or a single status item (closed or an error code).
// The last flag marks the final item caused by one input request; bytes that
//   cause nothing (backslash, opening quote, non-final hex digits) give none.
// Throughput: one input request per cycle while the queue has room. Output is
//   one item per cycle while out_ready is high; an escape that yields N bytes
//   holds the serializer till N are sent; a 4-byte pair comes from 12 input bytes.
// Path: a taken input request is written into the queue; the serializer then
//   loads its first item into the output register, which drives out_data.
// Stalls: when out_ready is low the output register holds; the 4-entry
//   request queue fills, and only then in_ready drops.
// Reset: rst_n clears parser state (waiting for an opening quote), empties
//   the queue and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none
module json_string_unescape_utf8_unit
    import jsu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    logic push;
    req_t push_req;
    logic q_full;
    logic pop;
    req_t head;
    logic q_empty;

    // Parser: classifies each byte and builds a result request.
    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .push_req (push_req)
    );

    // Decouples parsing from output backpressure.
    jsu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    // Serializer: one item per cycle from the queue head while out_ready is high.
    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ===== hdl/jsu_front.sv =====
// Parser front end: accepts input bytes and turns them into result requests.
`timescale 1ns / 1ps
`default_nettype none
module jsu_front
    import jsu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    input  wire logic q_full,
    output logic      push,
    output req_t      push_req
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic req_t status_req(input status_t s);
        req_t r;
        r.last_idx = 2'd0;
        r.status   = s;
        r.bytes    = '0;
        return r;
    endfunction

    function automatic req_t byte_req(input logic [7:0] b);
        req_t r;
        r          = status_req(ST_DATA);
        r.bytes[0] = b;
        return r;
    endfunction

    function automatic req_t utf8_req(input logic [20:0] cp);
        req_t r;
        r = status_req(ST_DATA);
        if (cp < 21'h80)
        begin
            r.bytes[0] = cp[7:0];
        end
        else if (cp < 21'h800)
        begin
            r.last_idx = 2'd1;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000)
        begin
            r.last_idx = 2'd2;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            r.last_idx = 2'd3;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [15:0] hex_value_reg, hex_value_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [9:0]  high_half_reg, high_half_next;

    logic        accept;
    logic [4:0]  dig;
    logic [15:0] hv_shift;
    logic        hex_done;
    logic [10:0] plane;
    logic [7:0]  b;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_data.in_byte;
    assign dig      = hex_digit(b);
    assign hv_shift = {hex_value_reg[11:0], dig[3:0]};
    assign hex_done = (hex_count_reg == 2'd3);
    // Supplementary plane from the high half: 0x10000 >> 10 is 64.
    assign plane    = {1'b0, high_half_reg} + 11'd64;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            hex_value_reg <= '0;
            hex_count_reg <= '0;
            high_half_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hex_value_reg <= hex_value_next;
            hex_count_reg <= hex_count_next;
            high_half_reg <= high_half_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        hex_value_next = hex_value_reg;
        hex_count_next = hex_count_reg;
        high_half_next = high_half_reg;
        push           = 1'b0;
        push_req       = status_req(ST_DATA);

        if (accept && in_data.end_of_input)
        begin
            phase_next = PH_WAIT;
            case (phase_reg)
                PH_TEXT, PH_ESC:
                begin
                    push     = 1'b1;
                    push_req = status_req(ST_UNTERM);
                end
                PH_HEX1, PH_HEX2:
                begin
                    push     = 1'b1;
                    push_req = status_req(ST_TRUNCATED);
                end
                PH_PAIR_BS, PH_PAIR_U:
                begin
                    push     = 1'b1;
                    push_req = status_req(ST_LONE_HALF);
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            case (phase_reg)
                PH_TEXT:
                begin
                    if (b == CH_QUOTE)
                    begin
                        push       = 1'b1;
                        push_req   = status_req(ST_CLOSED);
                        phase_next = PH_WAIT;
                    end
                    else if (b == CH_BSLASH)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        push     = 1'b1;
                        push_req = byte_req(b);
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_TEXT;
                    push       = 1'b1;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: push_req = byte_req(b);
                        CH_B: push_req = byte_req(8'h08);
                        CH_F: push_req = byte_req(8'h0C);
                        CH_N: push_req = byte_req(8'h0A);
                        CH_R: push_req = byte_req(8'h0D);
                        CH_T: push_req = byte_req(8'h09);
                        CH_U:
                        begin
                            push           = 1'b0;
                            hex_value_next = '0;
                            hex_count_next = '0;
                            phase_next     = PH_HEX1;
                        end
                        default:
                        begin
                            push_req   = status_req(ST_BAD_ESC);
                            phase_next = PH_WAIT;
                        end
                    endcase
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (!dig[4])
                    begin
                        push       = 1'b1;
                        push_req   = status_req(ST_BAD_HEX);
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        hex_value_next = hv_shift;
                        hex_count_next = hex_done ? 2'd0 : hex_count_reg + 2'd1;
                        if (hex_done && phase_reg == PH_HEX1)
                        begin
                            if (hv_shift[15:10] == 6'b110110)
                            begin
                                high_half_next = hv_shift[9:0];
                                phase_next     = PH_PAIR_BS;
                            end
                            else if (hv_shift[15:10] == 6'b110111)
                            begin
                                push       = 1'b1;
                                push_req   = status_req(ST_LONE_HALF);
                                phase_next = PH_WAIT;
                            end
                            else
                            begin
                                push       = 1'b1;
                                push_req   = utf8_req({5'd0, hv_shift});
                                phase_next = PH_TEXT;
                            end
                        end
                        else if (hex_done)
                        begin
                            push = 1'b1;
                            if (hv_shift[15:10] != 6'b110111)
                            begin
                                push_req   = status_req(ST_BAD_PAIR);
                                phase_next = PH_WAIT;
                            end
                            else
                            begin
                                push_req   = utf8_req({plane, hv_shift[9:0]});
                                phase_next = PH_TEXT;
                            end
                        end
                    end
                end
                PH_PAIR_BS:
                begin
                    if (b == CH_BSLASH)
                    begin
                        phase_next = PH_PAIR_U;
                    end
                    else
                    begin
                        push       = 1'b1;
                        push_req   = status_req(ST_LONE_HALF);
                        phase_next = PH_WAIT;
                    end
                end
                PH_PAIR_U:
                begin
                    if (b == CH_U)
                    begin
                        hex_value_next = '0;
                        hex_count_next = '0;
                        phase_next     = PH_HEX2;
                    end
                    else
                    begin
                        push       = 1'b1;
                        push_req   = status_req(ST_LONE_HALF);
                        phase_next = PH_WAIT;
                    end
                end
                default:
                begin
                    if (b == CH_QUOTE)
                    begin
                        phase_next = PH_TEXT;
                    end
                    else
                    begin
                        push       = 1'b1;
                        push_req   = status_req(ST_NO_QUOTE);
                        phase_next = PH_WAIT;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/jsu_queue.sv =====
// Short request queue between the parser and the output serializer.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_utf8_unit_defines.svh"
module jsu_queue
    import jsu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire req_t push_req,
    output logic      full,
    input  wire logic pop,
    output req_t      head,
    output logic      empty
);

    req_t                q_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_req;
        end
    end

    `JSU_ASSERT_IMPL(a_no_push_full, clk, rst_n, full, !push)
    `JSU_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, empty, !pop)
    `JSU_ASSERT_IMPL(a_ptr_gap, clk, rst_n, !full && !empty,
        wr_ptr_reg != rd_ptr_reg)
    `JSU_ASSERT_NEXT(a_count_step, clk, rst_n, push && !pop,
        count_reg == $past(count_reg) + 1'b1)

endmodule
`default_nettype wire

// ===== hdl/jsu_back.sv =====
// Serializer back end: walks each request and drives the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_utf8_unit_defines.svh"
module jsu_back
    import jsu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t head,
    input  wire logic empty,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    logic       out_valid_reg, out_valid_next;
    out_t       out_reg, out_next;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       head_last;

    assign load      = !out_valid_reg || out_ready;
    assign head_last = (idx_reg == head.last_idx);
    assign pop       = load && !empty && head_last;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        idx_next          = idx_reg;
        out_next.out_byte = head.bytes[idx_reg];
        out_next.status   = head.status;
        out_next.last     = head_last;
        if (load)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                idx_next = head_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    `JSU_ASSERT_IMPL(a_idx_bound, clk, rst_n, !empty, idx_reg <= head.last_idx)
    `JSU_ASSERT_IMPL(a_idx_idle, clk, rst_n, empty, idx_reg == 2'd0)
    `JSU_ASSERT_IMPL(a_status_alone, clk, rst_n,
        out_valid_reg && out_reg.status != ST_DATA,
        out_reg.last && out_reg.out_byte == 8'd0)

endmodule
`default_nettype wire
